// ===== hw/rtl/csl_pkg.sv =====
package csl_pkg;

    localparam int OFFSET_BITS     = 24;
    localparam int LINE_BITS       = 16;
    localparam int KEYWORD_MAX_LEN = 8;
    localparam int KIND_BITS       = 7;
    localparam int NUM_KEYWORDS    = 21;

    // token word queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int MAX_TOKENS = 3;

    typedef logic [KIND_BITS-1:0]   kind_t;
    typedef logic [OFFSET_BITS-1:0] offset_t;
    typedef logic [LINE_BITS-1:0]   line_t;
    typedef logic [4:0]             mode_t;

    // scanner modes
    localparam mode_t M_START = 5'd0;
    localparam mode_t M_IDENT = 5'd1;
    localparam mode_t M_NUM   = 5'd2;
    localparam mode_t M_STR   = 5'd3;
    localparam mode_t M_DOT1  = 5'd4;
    localparam mode_t M_DOT2  = 5'd5;
    localparam mode_t M_LTLT  = 5'd6;
    localparam mode_t M_GTGT  = 5'd7;
    localparam mode_t M_LCOM  = 5'd8;
    localparam mode_t M_BCOM  = 5'd9;
    localparam mode_t M_BSTAR = 5'd10;
    localparam mode_t M_OP    = 5'd11;
    localparam mode_t M_OP_LAST = 5'd22;

    // operator indexes relative to the first operator mode
    localparam logic [3:0] OP_SLASH = 4'd3;
    localparam logic [3:0] OP_LT    = 4'd5;
    localparam logic [3:0] OP_GT    = 4'd6;

    // token kinds
    localparam kind_t K_QUEST        = 7'd9;
    localparam kind_t K_COLON        = 7'd10;
    localparam kind_t K_DOT          = 7'd11;
    localparam kind_t K_OPS          = 7'd12;
    localparam kind_t K_ELLIPSIS     = 7'd24;
    localparam kind_t K_INC          = 7'd25;
    localparam kind_t K_ADD_ASSIGN   = 7'd26;
    localparam kind_t K_DEC          = 7'd27;
    localparam kind_t K_ARROW        = 7'd28;
    localparam kind_t K_SUB_ASSIGN   = 7'd29;
    localparam kind_t K_MUL_ASSIGN   = 7'd30;
    localparam kind_t K_DIV_ASSIGN   = 7'd31;
    localparam kind_t K_MOD_ASSIGN   = 7'd32;
    localparam kind_t K_LEFT_ASSIGN  = 7'd33;
    localparam kind_t K_LEFT_OP      = 7'd34;
    localparam kind_t K_LE           = 7'd35;
    localparam kind_t K_RIGHT_ASSIGN = 7'd36;
    localparam kind_t K_RIGHT_OP     = 7'd37;
    localparam kind_t K_GE           = 7'd38;
    localparam kind_t K_EQ           = 7'd39;
    localparam kind_t K_NE           = 7'd40;
    localparam kind_t K_AND          = 7'd41;
    localparam kind_t K_AND_ASSIGN   = 7'd42;
    localparam kind_t K_OR           = 7'd43;
    localparam kind_t K_OR_ASSIGN    = 7'd44;
    localparam kind_t K_XOR_ASSIGN   = 7'd45;
    localparam kind_t K_KW           = 7'd46;
    localparam kind_t K_IDENT        = 7'd67;
    localparam kind_t K_NUM          = 7'd68;
    localparam kind_t K_STR          = 7'd69;
    localparam kind_t K_END          = 7'd70;
    localparam kind_t K_ERR          = 7'd71;

    // keywords, first character in the lowest byte
    localparam logic [63:0] KW_WORD [NUM_KEYWORDS] = '{
        64'h72616863, 64'h65736c65, 64'h6669, 64'h746e69, 64'h6e7275746572,
        64'h64696f76, 64'h656c696877, 64'h666f657a6973, 64'h6b61657262,
        64'h65756e69746e6f63, 64'h6f64, 64'h726f66, 64'h746375727473,
        64'h686374697773, 64'h65736163, 64'h746c7561666564, 64'h6d756e65,
        64'h74726f6873, 64'h676e6f6c, 64'h636974617473, 64'h6e7265747865
    };
    localparam logic [3:0] KW_LEN [NUM_KEYWORDS] = '{
        4'd4, 4'd4, 4'd2, 4'd3, 4'd6, 4'd4, 4'd5, 4'd6, 4'd5, 4'd8, 4'd2,
        4'd3, 4'd6, 4'd6, 4'd4, 4'd7, 4'd4, 4'd5, 4'd4, 4'd6, 4'd6
    };

    typedef struct packed {
        logic    last;
        line_t   column;
        line_t   line;
        offset_t end_offset;
        offset_t start_offset;
        kind_t   kind;
    } token_t;

    typedef struct packed {
        logic  hit;
        kind_t kind;
    } follow_t;

    function automatic offset_t inc_off(input offset_t v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic line_t inc_line(input line_t v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_digit(c) || ((c >= "a") && (c <= "z")) ||
               ((c >= "A") && (c <= "Z")) || (c == "_");
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    function automatic kind_t word_kind(input logic [63:0] prefix, input logic [3:0] len);
        kind_t k;
        k = K_IDENT;
        for (int i = 0; i < NUM_KEYWORDS; i++)
        begin
            if ((len == KW_LEN[i]) && (prefix == KW_WORD[i]))
                k = K_KW + KIND_BITS'(i);
        end
        return k;
    endfunction

    // second character of a two-character operator
    function automatic follow_t op_follow(input logic [3:0] op, input logic [7:0] c);
        follow_t f;
        f = '{hit: 1'b0, kind: K_OPS};
        unique case (op)
            4'd0:
            begin
                if (c == "+") f = '{1'b1, K_INC};
                else if (c == "=") f = '{1'b1, K_ADD_ASSIGN};
            end
            4'd1:
            begin
                if (c == "-") f = '{1'b1, K_DEC};
                else if (c == ">") f = '{1'b1, K_ARROW};
                else if (c == "=") f = '{1'b1, K_SUB_ASSIGN};
            end
            4'd2:  if (c == "=") f = '{1'b1, K_MUL_ASSIGN};
            4'd3:  if (c == "=") f = '{1'b1, K_DIV_ASSIGN};
            4'd4:  if (c == "=") f = '{1'b1, K_MOD_ASSIGN};
            4'd5:  if (c == "=") f = '{1'b1, K_LE};
            4'd6:  if (c == "=") f = '{1'b1, K_GE};
            4'd7:  if (c == "=") f = '{1'b1, K_EQ};
            4'd8:  if (c == "=") f = '{1'b1, K_NE};
            4'd9:
            begin
                if (c == "&") f = '{1'b1, K_AND};
                else if (c == "=") f = '{1'b1, K_AND_ASSIGN};
            end
            4'd10:
            begin
                if (c == "|") f = '{1'b1, K_OR};
                else if (c == "=") f = '{1'b1, K_OR_ASSIGN};
            end
            4'd11: if (c == "=") f = '{1'b1, K_XOR_ASSIGN};
            default: f = '{hit: 1'b0, kind: K_OPS};
        endcase
        return f;
    endfunction

    function automatic token_t mk_token(input kind_t k, input offset_t s, input offset_t e,
                                        input line_t l, input line_t col);
        token_t t;
        t.last         = 1'b0;
        t.column       = col;
        t.line         = l;
        t.end_offset   = e;
        t.start_offset = s;
        t.kind         = k;
        return t;
    endfunction

endpackage

// ===== hw/rtl/c_subset_lexer_unit.sv =====
// c-subset lexer: takes source text one byte per word and gives tokens, one per output
// word. a token carries its kind, start and end byte offsets and the line and column of
// its first byte. whitespace and comments are skipped. an input word with tlast set, or
// a zero byte, ends the text: any pending token is flushed, an end token follows and the
// scanner returns to its reset state. the scanner handles each input word as it is taken
// and yields zero to three tokens, which enter an eight-word token queue; the
// input side is ready whenever the queue has room for three tokens, so a byte can be
// taken every cycle while the consumer drains one token per cycle. the final token that
// a byte causes carries tlast. offsets, lines and columns saturate at their maximum
module c_subset_lexer_unit
    import csl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // text_byte
    input  logic        s_tlast,    // end_of_text
    // token words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,    // token_kind, start_offset, end_offset, token_line,
                                    // token_column, zero pad
    output logic        m_tlast     // last_of_run
);

    // scanner state
    mode_t         mode_reg,   mode_next;
    logic [63:0]   prefix_reg, prefix_next;
    logic [3:0]    len_reg,    len_next;
    offset_t       off_reg,    off_next;
    line_t         line_reg,   line_next;
    line_t         col_reg,    col_next;
    offset_t       ps_reg,     ps_next;
    line_t         pl_reg,     pl_next;
    line_t         pc_reg,     pc_next;

    // token queue
    token_t                 fifo_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]       count_reg;

    logic        accept, pop;
    logic [7:0]  c;
    logic        fin;
    offset_t     pos, nxt;
    token_t      tok_a0, tok_a1, tok_b;
    logic [1:0]  na;
    logic        vb;
    logic        redo;
    logic [3:0]  op;
    follow_t     fol;
    token_t      lst [MAX_TOKENS];
    logic [1:0]  push_n;

    assign s_tready = count_reg <= (FIFO_AW+1)'(FIFO_DEPTH - MAX_TOKENS);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = count_reg != '0;
    assign pop      = m_tvalid && m_tready;

    assign m_tdata = {1'b0, fifo_reg[rd_ptr_reg].column, fifo_reg[rd_ptr_reg].line,
                      fifo_reg[rd_ptr_reg].end_offset, fifo_reg[rd_ptr_reg].start_offset,
                      fifo_reg[rd_ptr_reg].kind};
    assign m_tlast = fifo_reg[rd_ptr_reg].last;

    assign c   = s_tdata;
    assign fin = s_tlast || (c == 8'd0);
    assign pos = off_reg;
    assign nxt = inc_off(off_reg);
    assign op  = 4'(mode_reg - M_OP);
    assign fol = op_follow(op, c);

    // scanner: pending token first, then the byte again from the start state
    always_comb
    begin
        mode_next   = mode_reg;
        prefix_next = prefix_reg;
        len_next    = len_reg;
        off_next    = off_reg;
        line_next   = line_reg;
        col_next    = col_reg;
        ps_next     = ps_reg;
        pl_next     = pl_reg;
        pc_next     = pc_reg;
        tok_a0      = '0;
        tok_a1      = '0;
        tok_b       = '0;
        na          = 2'd0;
        vb          = 1'b0;
        redo        = 1'b0;

        if (fin)
        begin
            // flush whatever is pending
            if (mode_reg == M_IDENT)
            begin
                tok_a0 = mk_token(word_kind(prefix_reg, len_reg), ps_reg, pos, pl_reg, pc_reg);
                na = 2'd1;
            end
            else if (mode_reg == M_NUM)
            begin
                tok_a0 = mk_token(K_NUM, ps_reg, pos, pl_reg, pc_reg);
                na = 2'd1;
            end
            else if ((mode_reg == M_STR) || (mode_reg == M_BCOM) || (mode_reg == M_BSTAR))
            begin
                tok_a0 = mk_token(K_ERR, ps_reg, pos, pl_reg, pc_reg);
                na = 2'd1;
            end
            else if (mode_reg == M_DOT1)
            begin
                tok_a0 = mk_token(K_DOT, ps_reg, pos, pl_reg, pc_reg);
                na = 2'd1;
            end
            else if (mode_reg == M_DOT2)
            begin
                tok_a0 = mk_token(K_DOT, ps_reg, inc_off(ps_reg), pl_reg, pc_reg);
                tok_a1 = mk_token(K_DOT, inc_off(ps_reg), pos, pl_reg, inc_line(pc_reg));
                na = 2'd2;
            end
            else if (mode_reg == M_LTLT)
            begin
                tok_a0 = mk_token(K_LEFT_OP, ps_reg, pos, pl_reg, pc_reg);
                na = 2'd1;
            end
            else if (mode_reg == M_GTGT)
            begin
                tok_a0 = mk_token(K_RIGHT_OP, ps_reg, pos, pl_reg, pc_reg);
                na = 2'd1;
            end
            else if ((mode_reg >= M_OP) && (mode_reg <= M_OP_LAST))
            begin
                tok_a0 = mk_token(K_OPS + KIND_BITS'(op), ps_reg, pos, pl_reg, pc_reg);
                na = 2'd1;
            end
            tok_b = mk_token(K_END, pos, pos, line_reg, col_reg);
            vb    = 1'b1;
            // back to reset state
            mode_next   = M_START;
            prefix_next = '0;
            len_next    = '0;
            off_next    = '0;
            line_next   = LINE_BITS'(1);
            col_next    = LINE_BITS'(1);
            ps_next     = '0;
            pl_next     = LINE_BITS'(1);
            pc_next     = LINE_BITS'(1);
        end
        else
        begin
            if (mode_reg == M_START)
            begin
                redo = 1'b1;
            end
            else if ((mode_reg >= M_OP) && (mode_reg <= M_OP_LAST))
            begin
                if ((op == OP_SLASH) && (c == "/"))
                    mode_next = M_LCOM;
                else if ((op == OP_SLASH) && (c == "*"))
                    mode_next = M_BCOM;
                else if ((op == OP_LT) && (c == "<"))
                    mode_next = M_LTLT;
                else if ((op == OP_GT) && (c == ">"))
                    mode_next = M_GTGT;
                else if (fol.hit)
                begin
                    tok_a0 = mk_token(fol.kind, ps_reg, nxt, pl_reg, pc_reg);
                    na = 2'd1;
                    mode_next = M_START;
                end
                else
                begin
                    tok_a0 = mk_token(K_OPS + KIND_BITS'(op), ps_reg, pos, pl_reg, pc_reg);
                    na = 2'd1;
                    redo = 1'b1;
                end
            end
            else if (mode_reg == M_IDENT)
            begin
                if (is_word(c))
                begin
                    if (len_reg < 4'(KEYWORD_MAX_LEN))
                        prefix_next[{len_reg[2:0], 3'b000} +: 8] = c;
                    if (len_reg != 4'd15)
                        len_next = len_reg + 4'd1;
                end
                else
                begin
                    tok_a0 = mk_token(word_kind(prefix_reg, len_reg), ps_reg, pos, pl_reg,
                                      pc_reg);
                    na = 2'd1;
                    redo = 1'b1;
                end
            end
            else if (mode_reg == M_NUM)
            begin
                if (!is_digit(c))
                begin
                    tok_a0 = mk_token(K_NUM, ps_reg, pos, pl_reg, pc_reg);
                    na = 2'd1;
                    redo = 1'b1;
                end
            end
            else if (mode_reg == M_STR)
            begin
                if (c == "\"")
                begin
                    tok_a0 = mk_token(K_STR, ps_reg, nxt, pl_reg, pc_reg);
                    na = 2'd1;
                    mode_next = M_START;
                end
            end
            else if (mode_reg == M_DOT1)
            begin
                if (c == ".")
                    mode_next = M_DOT2;
                else
                begin
                    tok_a0 = mk_token(K_DOT, ps_reg, pos, pl_reg, pc_reg);
                    na = 2'd1;
                    redo = 1'b1;
                end
            end
            else if (mode_reg == M_DOT2)
            begin
                if (c == ".")
                begin
                    tok_a0 = mk_token(K_ELLIPSIS, ps_reg, nxt, pl_reg, pc_reg);
                    na = 2'd1;
                    mode_next = M_START;
                end
                else
                begin
                    // two separate dots
                    tok_a0 = mk_token(K_DOT, ps_reg, inc_off(ps_reg), pl_reg, pc_reg);
                    tok_a1 = mk_token(K_DOT, inc_off(ps_reg), pos, pl_reg, inc_line(pc_reg));
                    na = 2'd2;
                    redo = 1'b1;
                end
            end
            else if ((mode_reg == M_LTLT) || (mode_reg == M_GTGT))
            begin
                if (c == "=")
                begin
                    tok_a0 = mk_token((mode_reg == M_LTLT) ? K_LEFT_ASSIGN : K_RIGHT_ASSIGN,
                                      ps_reg, nxt, pl_reg, pc_reg);
                    na = 2'd1;
                    mode_next = M_START;
                end
                else
                begin
                    tok_a0 = mk_token((mode_reg == M_LTLT) ? K_LEFT_OP : K_RIGHT_OP,
                                      ps_reg, pos, pl_reg, pc_reg);
                    na = 2'd1;
                    redo = 1'b1;
                end
            end
            else if (mode_reg == M_LCOM)
            begin
                if (c == 8'd10)
                    mode_next = M_START;
            end
            else if ((mode_reg == M_BCOM) || (mode_reg == M_BSTAR))
            begin
                if ((mode_reg == M_BSTAR) && (c == "/"))
                    mode_next = M_START;
                else
                    mode_next = (c == "*") ? M_BSTAR : M_BCOM;
            end
            else
            begin
                // unused mode code
                redo = 1'b1;
            end

            // byte seen from the start state
            if (redo)
            begin
                mode_next = M_START;
                if (!is_space(c))
                begin
                    ps_next = pos;
                    pl_next = line_reg;
                    pc_next = col_reg;
                    if (c == "\"")
                        mode_next = M_STR;
                    else if (c == "?")
                    begin
                        tok_b = mk_token(K_QUEST, pos, nxt, line_reg, col_reg);
                        vb = 1'b1;
                    end
                    else if ((c == "(") || (c == ")") || (c == ",") || (c == ";") ||
                             (c == "[") || (c == "]") || (c == "{") || (c == "}") ||
                             (c == "~") || (c == ":"))
                    begin
                        priority case (c)
                            "(":     tok_b.kind = 7'd0;
                            ")":     tok_b.kind = 7'd1;
                            ",":     tok_b.kind = 7'd2;
                            ";":     tok_b.kind = 7'd3;
                            "[":     tok_b.kind = 7'd4;
                            "]":     tok_b.kind = 7'd5;
                            "{":     tok_b.kind = 7'd6;
                            "}":     tok_b.kind = 7'd7;
                            "~":     tok_b.kind = 7'd8;
                            default: tok_b.kind = K_COLON;
                        endcase
                        tok_b.start_offset = pos;
                        tok_b.end_offset   = nxt;
                        tok_b.line         = line_reg;
                        tok_b.column       = col_reg;
                        vb = 1'b1;
                    end
                    else if (c == ".")
                        mode_next = M_DOT1;
                    else if ((c == "+") || (c == "-") || (c == "*") || (c == "/") ||
                             (c == "%") || (c == "<") || (c == ">") || (c == "=") ||
                             (c == "!") || (c == "&") || (c == "|") || (c == "^"))
                    begin
                        priority case (c)
                            "+":     mode_next = M_OP + 5'd0;
                            "-":     mode_next = M_OP + 5'd1;
                            "*":     mode_next = M_OP + 5'd2;
                            "/":     mode_next = M_OP + 5'd3;
                            "%":     mode_next = M_OP + 5'd4;
                            "<":     mode_next = M_OP + 5'd5;
                            ">":     mode_next = M_OP + 5'd6;
                            "=":     mode_next = M_OP + 5'd7;
                            "!":     mode_next = M_OP + 5'd8;
                            "&":     mode_next = M_OP + 5'd9;
                            "|":     mode_next = M_OP + 5'd10;
                            default: mode_next = M_OP + 5'd11;
                        endcase
                    end
                    else if (is_digit(c))
                        mode_next = M_NUM;
                    else
                    begin
                        mode_next   = M_IDENT;
                        prefix_next = {56'd0, c};
                        len_next    = 4'd1;
                    end
                end
            end

            // position counters
            off_next = nxt;
            if (c == 8'd10)
            begin
                line_next = inc_line(line_reg);
                col_next  = LINE_BITS'(1);
            end
            else
                col_next = inc_line(col_reg);
        end
    end

    // order the tokens of this byte and mark the final one
    always_comb
    begin
        lst[0] = tok_a0;
        lst[1] = tok_a1;
        lst[2] = '0;
        if (vb)
            lst[na] = tok_b;
        push_n = na + {1'b0, vb};
        if (push_n != 2'd0)
            lst[push_n - 2'd1].last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= M_START;
            prefix_reg <= '0;
            len_reg    <= '0;
            off_reg    <= '0;
            line_reg   <= LINE_BITS'(1);
            col_reg    <= LINE_BITS'(1);
            ps_reg     <= '0;
            pl_reg     <= LINE_BITS'(1);
            pc_reg     <= LINE_BITS'(1);
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                mode_reg   <= mode_next;
                prefix_reg <= prefix_next;
                len_reg    <= len_next;
                off_reg    <= off_next;
                line_reg   <= line_next;
                col_reg    <= col_next;
                ps_reg     <= ps_next;
                pl_reg     <= pl_next;
                pc_reg     <= pc_next;
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(push_n);
            end
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_reg + (accept ? (FIFO_AW+1)'(push_n) : '0)
                         - (pop ? (FIFO_AW+1)'(1) : '0);
        end
    end

    // queue storage, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int k = 0; k < MAX_TOKENS; k++)
            begin
                if (k < int'(push_n))
                    fifo_reg[wr_ptr_reg + FIFO_AW'(k)] <= lst[k];
            end
        end
    end

endmodule
